/* src/slt_pkg.sv */
// Types and constants shared by the tokenizer modules.
// No dependencies.
package slt_pkg;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_NUMBER, M_COLON, M_DOT, M_QUOTE, M_QUOTE_CH, M_COMMENT
	} mode_t;

	localparam logic [5:0] K_ID      = 6'd21;
	localparam logic [5:0] K_NUM     = 6'd22;
	localparam logic [5:0] K_CHARLIT = 6'd23;
	localparam logic [5:0] K_ASSIGN  = 6'd24;
	localparam logic [5:0] K_DOT     = 6'd33;
	localparam logic [5:0] K_RANGE   = 6'd38;
	localparam logic [5:0] K_NONE    = 6'd63;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam int KW_COUNT = 21;
	localparam int KW_MAX   = 9;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] line_count;
		logic [19:0] start_offset;
		logic [7:0]  token_length;
		logic [31:0] number_value;
		logic        number_overflow;
		logic [7:0]  literal_char;
		logic        last_of_run;
	} out_item_t;

	typedef logic [KW_MAX*8-1:0] kw_text_t;

	// Reserved words, first character in the low byte, zero padded.
	function automatic kw_text_t kw_text(input logic [4:0] k);
		kw_text_t t;
		t = '0;
		case (k)
			5'd0:  t = kw_text_t'({"margorp"});
			5'd1:  t = kw_text_t'({"epyt"});
			5'd2:  t = kw_text_t'({"rav"});
			5'd3:  t = kw_text_t'({"erudecorp"});
			5'd4:  t = kw_text_t'({"nigeb"});
			5'd5:  t = kw_text_t'({"dne"});
			5'd6:  t = kw_text_t'({"yarra"});
			5'd7:  t = kw_text_t'({"fo"});
			5'd8:  t = kw_text_t'({"drocer"});
			5'd9:  t = kw_text_t'({"fi"});
			5'd10: t = kw_text_t'({"neht"});
			5'd11: t = kw_text_t'({"esle"});
			5'd12: t = kw_text_t'({"if"});
			5'd13: t = kw_text_t'({"rahc"});
			5'd14: t = kw_text_t'({"elihw"});
			5'd15: t = kw_text_t'({"od"});
			5'd16: t = kw_text_t'({"hwdne"});
			5'd17: t = kw_text_t'({"daer"});
			5'd18: t = kw_text_t'({"etirw"});
			5'd19: t = kw_text_t'({"nruter"});
			5'd20: t = kw_text_t'({"regetni"});
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input logic [4:0] k);
		logic [3:0] n;
		case (k)
			5'd0, 5'd20: n = 4'd7;
			5'd1, 5'd10, 5'd11, 5'd13, 5'd17: n = 4'd4;
			5'd2, 5'd5: n = 4'd3;
			5'd3: n = 4'd9;
			5'd4, 5'd6, 5'd14, 5'd16, 5'd18: n = 4'd5;
			5'd7, 5'd9, 5'd12, 5'd15: n = 4'd2;
			5'd8, 5'd19: n = 4'd6;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [5:0] sep_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			8'h3D: k = 6'd25;
			8'h3C: k = 6'd26;
			8'h2B: k = 6'd27;
			8'h2D: k = 6'd28;
			8'h2A: k = 6'd29;
			8'h2F: k = 6'd30;
			8'h28: k = 6'd31;
			8'h29: k = 6'd32;
			8'h3B: k = 6'd34;
			8'h2C: k = 6'd35;
			8'h5B: k = 6'd36;
			8'h5D: k = 6'd37;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

endpackage

/* src/slt_kw_match.sv */
// Parallel compare of the held word against the reserved words.
// Depends on slt_pkg.
module slt_kw_match #(
	parameter int KEYWORD_CHARS = 9
) (
	input  logic [KEYWORD_CHARS*8-1:0] word,
	input  logic [7:0]                 len,
	output logic [5:0]                 kind
);
	always_comb begin
		logic [KEYWORD_CHARS*8-1:0] t;
		kind = slt_pkg::K_ID;
		for (int k = slt_pkg::KW_COUNT - 1; k >= 0; k--) begin
			t = '0;
			t[slt_pkg::KW_MAX*8-1:0] = slt_pkg::kw_text(5'(k));
			if (len == 8'(slt_pkg::kw_len(5'(k))) && word == t)
				kind = 6'(k);
		end
	end
endmodule

/* src/slt_core.sv */
// Lexer state and per-character token decode; up to two tokens per character.
// Depends on slt_pkg and slt_kw_match.
module slt_core #(
	parameter int NUMBER_BITS   = 32,
	parameter int OFFSET_BITS   = 20,
	parameter int KEYWORD_CHARS = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  slt_pkg::in_item_t   item,
	output slt_pkg::out_item_t  tok0,
	output slt_pkg::out_item_t  tok1,
	output logic [1:0]          count
);
	localparam logic [NUMBER_BITS-1:0] NMAX = '1;
	localparam int WI = $clog2(KEYWORD_CHARS);

	slt_pkg::mode_t mode_q, mode_d;
	logic [7:0] wbuf_q [KEYWORD_CHARS];
	logic [7:0] wlen_q, wlen_d;
	logic [NUMBER_BITS-1:0] acc_q, acc_d;
	logic ovf_q, ovf_d;
	logic [15:0] line_q, line_d;
	logic [OFFSET_BITS-1:0] off_q, tstart_q, tstart_d;
	logic [7:0] lit_q, lit_d;
	logic wr_en;
	logic [7:0] wr_idx, wr_chr;

	logic [KEYWORD_CHARS*8-1:0] word_flat;
	logic [5:0] kw_kind;

	// Kind of the word as it stands after this character is added.
	logic [5:0] kw_next;
	logic [KEYWORD_CHARS*8-1:0] word_next;

	always_comb begin
		word_flat = '0;
		for (int i = 0; i < KEYWORD_CHARS; i++)
			if (8'(i) < wlen_q)
				word_flat[i*8 +: 8] = wbuf_q[i];
	end

	slt_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw (
		.word(word_flat), .len(wlen_q), .kind(kw_kind)
	);

	always_comb begin
		word_next = '0;
		for (int i = 0; i < KEYWORD_CHARS; i++) begin
			if (8'(i) < wlen_d) begin
				if (wr_en && wr_idx == 8'(i)) word_next[i*8 +: 8] = wr_chr;
				else if (mode_q == slt_pkg::M_QUOTE_CH && i == 0)
					word_next[i*8 +: 8] = lit_q;
				else word_next[i*8 +: 8] = wbuf_q[i];
			end
		end
	end

	slt_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw_next (
		.word(word_next), .len(wlen_d), .kind(kw_next)
	);

	// One digit step: acc*10+d with saturation at the top of range.
	function automatic logic [NUMBER_BITS:0] dstep(input logic [NUMBER_BITS-1:0] a,
			input logic [7:0] c);
		logic [NUMBER_BITS+4:0] p;
		p = ({5'd0, a} << 3) + ({5'd0, a} << 1) + (NUMBER_BITS+5)'(c - 8'h30);
		if (p[NUMBER_BITS+4:NUMBER_BITS] != '0)
			return {1'b1, NMAX};
		return {1'b0, p[NUMBER_BITS-1:0]};
	endfunction

	always_comb begin
		logic [7:0] c;
		logic [OFFSET_BITS-1:0] off;
		logic [5:0] sk;
		logic idle_go, lett, dig;
		logic [NUMBER_BITS:0] ds;
		slt_pkg::out_item_t t [2];
		logic [1:0] n;
		logic [5:0] wk;
		c = item.char_code;
		off = off_q;
		sk = slt_pkg::sep_kind(c);
		lett = slt_pkg::is_letter(c);
		dig = slt_pkg::is_digit(c);
		mode_d = mode_q; wlen_d = wlen_q; acc_d = acc_q; ovf_d = ovf_q;
		line_d = line_q; tstart_d = tstart_q; lit_d = lit_q;
		wr_en = 1'b0; wr_idx = wlen_q; wr_chr = c;
		idle_go = 1'b0;
		n = '0;
		t[0] = '0; t[1] = '0;
		wk = (wlen_q > 8'(KEYWORD_CHARS)) ? slt_pkg::K_ID : kw_kind;
		ds = dstep(acc_q, c);
		case (mode_q)
			slt_pkg::M_QUOTE_CH: begin
				if (c == slt_pkg::CH_QUOTE) begin
					t[0].token_kind = slt_pkg::K_CHARLIT;
					t[0].start_offset = 20'(tstart_q);
					t[0].token_length = 8'd3;
					t[0].literal_char = lit_q;
					n = 2'd1;
					mode_d = slt_pkg::M_IDLE;
				end else begin
					// held char starts a word or number one offset back
					tstart_d = off - OFFSET_BITS'(1);
					if (slt_pkg::is_letter(lit_q)) begin
						if (lett || dig) begin
							mode_d = slt_pkg::M_WORD;
							wr_en = 1'b1; wr_idx = 8'd1;
							wlen_d = 8'd2;
						end else begin
							// held letter: one-char word (never reserved), then rerun c
							t[0].token_kind = slt_pkg::K_ID;
							t[0].start_offset = 20'(off - OFFSET_BITS'(1));
							t[0].token_length = 8'd1;
							n = 2'd1;
							idle_go = 1'b1;
						end
					end else begin
						if (dig) begin
							mode_d = slt_pkg::M_NUMBER;
							acc_d = NUMBER_BITS'(lit_q - 8'h30) * NUMBER_BITS'(10)
								+ NUMBER_BITS'(c - 8'h30);
							ovf_d = 1'b0;
							wlen_d = 8'd2;
						end else begin
							t[0].token_kind = slt_pkg::K_NUM;
							t[0].start_offset = 20'(off - OFFSET_BITS'(1));
							t[0].token_length = 8'd1;
							t[0].number_value = 32'(NUMBER_BITS'(lit_q - 8'h30));
							n = 2'd1;
							idle_go = 1'b1;
						end
					end
				end
			end
			slt_pkg::M_WORD: begin
				if (lett || dig) begin
					wr_en = wlen_q < 8'(KEYWORD_CHARS);
					if (wlen_q != 8'd255) wlen_d = wlen_q + 8'd1;
				end else begin
					t[0].token_kind = wk;
					t[0].start_offset = 20'(tstart_q);
					t[0].token_length = wlen_q;
					n = 2'd1;
					idle_go = 1'b1;
				end
			end
			slt_pkg::M_NUMBER: begin
				if (dig) begin
					acc_d = ds[NUMBER_BITS-1:0];
					if (ds[NUMBER_BITS]) ovf_d = 1'b1;
					if (wlen_q != 8'd255) wlen_d = wlen_q + 8'd1;
				end else begin
					t[0].token_kind = slt_pkg::K_NUM;
					t[0].start_offset = 20'(tstart_q);
					t[0].token_length = wlen_q;
					t[0].number_value = 32'(acc_q);
					t[0].number_overflow = ovf_q;
					n = 2'd1;
					idle_go = 1'b1;
				end
			end
			slt_pkg::M_COLON: begin
				if (c == slt_pkg::CH_EQUAL) begin
					t[0].token_kind = slt_pkg::K_ASSIGN;
					t[0].start_offset = 20'(tstart_q);
					t[0].token_length = 8'd2;
					n = 2'd1;
					mode_d = slt_pkg::M_IDLE;
				end else idle_go = 1'b1;
			end
			slt_pkg::M_DOT: begin
				t[0].start_offset = 20'(tstart_q);
				n = 2'd1;
				if (c == slt_pkg::CH_DOT) begin
					t[0].token_kind = slt_pkg::K_RANGE;
					t[0].token_length = 8'd2;
					mode_d = slt_pkg::M_IDLE;
				end else begin
					t[0].token_kind = slt_pkg::K_DOT;
					t[0].token_length = 8'd1;
					idle_go = 1'b1;
				end
			end
			slt_pkg::M_QUOTE: begin
				if (lett || dig) begin
					lit_d = c;
					mode_d = slt_pkg::M_QUOTE_CH;
				end else idle_go = 1'b1;
			end
			slt_pkg::M_COMMENT: begin
				if (c == slt_pkg::CH_RBRACE) mode_d = slt_pkg::M_IDLE;
				else if (c == slt_pkg::CH_NL) line_d = line_q + 16'd1;
			end
			default: idle_go = 1'b1;
		endcase

		if (idle_go) begin
			mode_d = slt_pkg::M_IDLE;
			if (lett || dig) begin
				tstart_d = off;
				wlen_d = 8'd1;
				if (lett) begin
					mode_d = slt_pkg::M_WORD;
					wr_en = 1'b1; wr_idx = 8'd0;
				end else begin
					mode_d = slt_pkg::M_NUMBER;
					acc_d = NUMBER_BITS'(c - 8'h30);
					ovf_d = 1'b0;
				end
			end else if (sk != slt_pkg::K_NONE) begin
				t[n[0]] = '0;
				t[n[0]].token_kind = sk;
				t[n[0]].start_offset = 20'(off);
				t[n[0]].token_length = 8'd1;
				n = n + 2'd1;
			end else if (c == slt_pkg::CH_NL) begin
				line_d = line_q + 16'd1;
			end else if (c == slt_pkg::CH_COLON) begin
				tstart_d = off; mode_d = slt_pkg::M_COLON;
			end else if (c == slt_pkg::CH_DOT) begin
				tstart_d = off; mode_d = slt_pkg::M_DOT;
			end else if (c == slt_pkg::CH_QUOTE) begin
				tstart_d = off; mode_d = slt_pkg::M_QUOTE;
			end else if (c == slt_pkg::CH_LBRACE) begin
				mode_d = slt_pkg::M_COMMENT;
			end
		end

		// end of input: flush whatever the next state holds
		if (item.end_of_input) begin
			case (mode_d)
				slt_pkg::M_DOT: begin
					t[n[0]] = '0;
					t[n[0]].token_kind = slt_pkg::K_DOT;
					t[n[0]].start_offset = 20'(tstart_d);
					t[n[0]].token_length = 8'd1;
					n = n + 2'd1;
				end
				slt_pkg::M_QUOTE_CH: begin
					t[n[0]] = '0;
					t[n[0]].start_offset = 20'(tstart_d + OFFSET_BITS'(1));
					t[n[0]].token_length = 8'd1;
					if (slt_pkg::is_letter(lit_d))
						t[n[0]].token_kind = slt_pkg::K_ID;
					else begin
						t[n[0]].token_kind = slt_pkg::K_NUM;
						t[n[0]].number_value = 32'(NUMBER_BITS'(lit_d - 8'h30));
					end
					n = n + 2'd1;
				end
				slt_pkg::M_WORD: begin
					t[n[0]] = '0;
					t[n[0]].token_kind = (wlen_d > 8'(KEYWORD_CHARS)) ? slt_pkg::K_ID
						: kw_next;
					t[n[0]].start_offset = 20'(tstart_d);
					t[n[0]].token_length = wlen_d;
					n = n + 2'd1;
				end
				slt_pkg::M_NUMBER: begin
					t[n[0]] = '0;
					t[n[0]].token_kind = slt_pkg::K_NUM;
					t[n[0]].start_offset = 20'(tstart_d);
					t[n[0]].token_length = wlen_d;
					t[n[0]].number_value = 32'(acc_d);
					t[n[0]].number_overflow = ovf_d;
					n = n + 2'd1;
				end
				default: ;
			endcase
			mode_d = slt_pkg::M_IDLE;
		end
		// tokens carry the line count before this byte; a newline here counts from the next byte on
		t[0].line_count = line_q;
		t[1].line_count = line_q;
		if (n == 2'd1) t[0].last_of_run = 1'b1;
		if (n == 2'd2) t[1].last_of_run = 1'b1;
		tok0 = t[0];
		tok1 = t[1];
		count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= slt_pkg::M_IDLE;
			wlen_q <= '0; acc_q <= '0; ovf_q <= 1'b0; line_q <= '0;
			off_q <= '0; tstart_q <= '0; lit_q <= '0;
		end else if (step) begin
			mode_q <= mode_d; wlen_q <= wlen_d; acc_q <= acc_d; ovf_q <= ovf_d;
			line_q <= line_d; off_q <= off_q + OFFSET_BITS'(1);
			tstart_q <= tstart_d; lit_q <= lit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (mode_q == slt_pkg::M_QUOTE_CH && mode_d == slt_pkg::M_WORD)
				wbuf_q[0] <= lit_q;
			if (wr_en && wr_idx < 8'(KEYWORD_CHARS))
				wbuf_q[wr_idx[WI-1:0]] <= wr_chr;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_of_input |=> mode_q == slt_pkg::M_IDLE)
		else $error("mode not idle after end of input");
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> off_q == $past(off_q) + OFFSET_BITS'(1))
		else $error("offset did not advance");
	assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == slt_pkg::M_COMMENT && !item.end_of_input |-> count == 2'd0)
		else $error("token inside comment");
endmodule

/* src/small_language_tokenizer.sv */
// Top level of the tokenizer: input register, lexer core, four-entry result queue.
// Depends on slt_pkg and slt_core.
//
// Usage: one source byte is sent per transfer on in_valid/in_ready/in_item;
// tokens leave on out_valid/out_ready/out_item, at most two per byte, the
// last one of a byte marked by last_of_run. Set end_of_input on the final
// byte to flush a pending token.
// Path: the byte that ends a token is held in the input register, and the core
// decodes it into the result queue, from which the token leaves on out_item.
// Throughput: one byte per cycle while the four-entry result queue drains;
// the held byte is decoded only when the queue has room for two tokens, so
// input stalls only while more than two tokens are left waiting.
// Reset: arst_n clears the lexer to idle, line and offset to zero, and
// empties the queue. When the receiver stalls, tokens wait in the queue
// and in_ready falls once the held byte cannot be decoded into it.
module small_language_tokenizer #(
	parameter int NUMBER_BITS   = 32,
	parameter int OFFSET_BITS   = 20,
	parameter int KEYWORD_CHARS = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  slt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output slt_pkg::out_item_t out_item
);
	slt_pkg::in_item_t item_s1;
	logic v_s1;
	slt_pkg::out_item_t tok0, tok1;
	logic [1:0] cnt;
	slt_pkg::out_item_t q_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] fill_q;
	logic step, pop;

	// decode the held byte once the queue has room for both possible tokens
	assign pop = out_valid && out_ready;
	assign step = v_s1 && (fill_q - {2'd0, pop} <= 3'd2);
	assign in_ready = !v_s1 || step;

	slt_core #(.NUMBER_BITS(NUMBER_BITS), .OFFSET_BITS(OFFSET_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .item(item_s1),
		.tok0(tok0), .tok1(tok1), .count(cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
	end

	logic [1:0] push;
	assign push = step ? cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; fill_q <= '0;
		end else begin
			rd_q <= rd_q + {1'b0, pop};
			wr_q <= wr_q + push;
			fill_q <= fill_q + {1'b0, push} - {2'd0, pop};
		end
	end
	always_ff @(posedge clk) begin
		if (push != 2'd0) q_q[wr_q] <= tok0;
		if (push == 2'd2) q_q[wr_q + 2'd1] <= tok1;
	end

	assign out_valid = fill_q != 3'd0;
	assign out_item = q_q[rd_q];

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 3'd4)
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		step |-> cnt != 2'd3)
		else $error("more than two tokens for one byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !step |=> v_s1 && $stable(item_s1))
		else $error("held byte lost");
endmodule

/* dv/slt_checker.sv */
// Token checker: predicts the tokens of each accepted source byte and compares
// every accepted token with the oldest prediction. Depends on slt_pkg.
module slt_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  slt_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  slt_pkg::out_item_t out_item,
	output int                 fail_count,
	output int                 pending
);
	localparam int WORD_KEEP = 9;

	slt_pkg::mode_t     mode;
	logic [7:0]         word_chars [WORD_KEEP];
	int unsigned        word_len;
	logic [31:0]        acc;
	logic               acc_sat;
	logic [15:0]        line_no;
	logic [19:0]        offset;
	logic [19:0]        tok_start;
	logic [7:0]         held_char;
	slt_pkg::out_item_t token_q [$];
	slt_pkg::out_item_t step_toks [$];

	function automatic logic letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] separator_kind(input logic [7:0] c);
		case (c)
			"=": return 6'd25;
			"<": return 6'd26;
			"+": return 6'd27;
			"-": return 6'd28;
			"*": return 6'd29;
			"/": return 6'd30;
			"(": return 6'd31;
			")": return 6'd32;
			";": return 6'd34;
			",": return 6'd35;
			"[": return 6'd36;
			"]": return 6'd37;
			default: return slt_pkg::K_NONE;
		endcase
	endfunction

	task automatic add_token(input logic [5:0] kind, input logic [19:0] start,
			input int unsigned len, input logic [31:0] val, input logic sat,
			input logic [7:0] lit);
		slt_pkg::out_item_t t;
		if (step_toks.size() >= 2) return;
		t.token_kind = kind;
		t.line_count = line_no;
		t.start_offset = start;
		t.token_length = len > 255 ? 8'd255 : len[7:0];
		t.number_value = val;
		t.number_overflow = sat;
		t.literal_char = lit;
		t.last_of_run = 1'b0;
		step_toks.push_back(t);
	endtask

	function automatic logic [5:0] word_class();
		string words [21] = '{"program", "type", "var", "procedure", "begin", "end",
			"array", "of", "record", "if", "then", "else", "fi", "char", "while", "do",
			"endwh", "read", "write", "return", "integer"};
		logic hit;
		if (word_len > WORD_KEEP) return slt_pkg::K_ID;
		for (int k = 0; k < 21; k++) begin
			if (words[k].len() != word_len) continue;
			hit = 1'b1;
			for (int i = 0; i < word_len; i++)
				if (words[k][i] != word_chars[i]) hit = 1'b0;
			if (hit) return k[5:0];
		end
		return slt_pkg::K_ID;
	endfunction

	task automatic close_word_or_number();
		if (mode == slt_pkg::M_WORD)
			add_token(word_class(), tok_start, word_len, '0, 1'b0, '0);
		else if (mode == slt_pkg::M_NUMBER)
			add_token(slt_pkg::K_NUM, tok_start, word_len, acc, acc_sat, '0);
	endtask

	task automatic open_token(input logic [7:0] c, input logic [19:0] start);
		tok_start = start;
		word_len = 1;
		if (letter(c)) begin
			mode = slt_pkg::M_WORD;
			word_chars[0] = c;
		end else begin
			mode = slt_pkg::M_NUMBER;
			acc = c - 8'h30;
			acc_sat = 1'b0;
		end
	endtask

	task automatic from_idle(input logic [7:0] c, input logic [19:0] off);
		logic [5:0] s;
		s = separator_kind(c);
		mode = slt_pkg::M_IDLE;
		if (letter(c) || digit(c)) open_token(c, off);
		else if (s != slt_pkg::K_NONE) add_token(s, off, 1, '0, 1'b0, '0);
		else if (c == slt_pkg::CH_NL) line_no++;
		else if (c == slt_pkg::CH_COLON) begin
			tok_start = off;
			mode = slt_pkg::M_COLON;
		end else if (c == slt_pkg::CH_DOT) begin
			tok_start = off;
			mode = slt_pkg::M_DOT;
		end else if (c == slt_pkg::CH_QUOTE) begin
			tok_start = off;
			mode = slt_pkg::M_QUOTE;
		end else if (c == slt_pkg::CH_LBRACE) mode = slt_pkg::M_COMMENT;
	endtask

	task automatic add_digit(input logic [7:0] c, input logic [19:0] off);
		logic [31:0] d;
		if (digit(c)) begin
			d = c - 8'h30;
			if (acc > (32'hFFFF_FFFF - d) / 10) begin
				acc = 32'hFFFF_FFFF;
				acc_sat = 1'b1;
			end else acc = acc * 10 + d;
			if (word_len < 255) word_len++;
		end else begin
			close_word_or_number();
			from_idle(c, off);
		end
	endtask

	task automatic add_letter(input logic [7:0] c, input logic [19:0] off);
		if (letter(c) || digit(c)) begin
			if (word_len < WORD_KEEP) word_chars[word_len] = c;
			if (word_len < 255) word_len++;
		end else begin
			close_word_or_number();
			from_idle(c, off);
		end
	endtask

	task automatic predict_tokens(input slt_pkg::in_item_t it);
		logic [7:0] c;
		c = it.char_code;
		step_toks.delete();
		case (mode)
			slt_pkg::M_QUOTE_CH: begin
				if (c == slt_pkg::CH_QUOTE) begin
					add_token(slt_pkg::K_CHARLIT, tok_start, 3, '0, 1'b0, held_char);
					mode = slt_pkg::M_IDLE;
				end else begin
					open_token(held_char, offset - 20'd1);
					if (mode == slt_pkg::M_NUMBER) add_digit(c, offset);
					else add_letter(c, offset);
				end
			end
			slt_pkg::M_WORD: add_letter(c, offset);
			slt_pkg::M_NUMBER: add_digit(c, offset);
			slt_pkg::M_COLON: begin
				if (c == slt_pkg::CH_EQUAL) begin
					add_token(slt_pkg::K_ASSIGN, tok_start, 2, '0, 1'b0, '0);
					mode = slt_pkg::M_IDLE;
				end else from_idle(c, offset);
			end
			slt_pkg::M_DOT: begin
				if (c == slt_pkg::CH_DOT) begin
					add_token(slt_pkg::K_RANGE, tok_start, 2, '0, 1'b0, '0);
					mode = slt_pkg::M_IDLE;
				end else begin
					add_token(slt_pkg::K_DOT, tok_start, 1, '0, 1'b0, '0);
					from_idle(c, offset);
				end
			end
			slt_pkg::M_QUOTE: begin
				if (letter(c) || digit(c)) begin
					held_char = c;
					mode = slt_pkg::M_QUOTE_CH;
				end else from_idle(c, offset);
			end
			slt_pkg::M_COMMENT: begin
				if (c == slt_pkg::CH_RBRACE) mode = slt_pkg::M_IDLE;
				else if (c == slt_pkg::CH_NL) line_no++;
			end
			default: from_idle(c, offset);
		endcase
		if (it.end_of_input) begin
			if (mode == slt_pkg::M_QUOTE_CH) open_token(held_char, tok_start + 20'd1);
			if (mode == slt_pkg::M_DOT)
				add_token(slt_pkg::K_DOT, tok_start, 1, '0, 1'b0, '0);
			else close_word_or_number();
			mode = slt_pkg::M_IDLE;
		end
		offset++;
		if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
		foreach (step_toks[i]) token_q.push_back(step_toks[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		slt_pkg::out_item_t want;
		if (!arst_n) begin
			mode = slt_pkg::M_IDLE;
			word_len = 0;
			acc = '0;
			acc_sat = 1'b0;
			line_no = '0;
			offset = '0;
			tok_start = '0;
			held_char = '0;
			fail_count <= 0;
			token_q.delete();
			pending <= 0;
		end else begin
			// compare before predicting: a token never leaves in its byte's cycle
			if (out_valid && out_ready) begin
				if (token_q.size() == 0) begin
					$display("%0t: unexpected token, expected none, actual %p", $realtime,
						out_item);
					fail_count <= fail_count + 1;
				end else begin
					want = token_q.pop_front();
					if (want !== out_item) begin
						$display("%0t: token mismatch, expected %p, actual %p", $realtime,
							want, out_item);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) predict_tokens(in_item);
			pending <= token_q.size();
		end
	end
endmodule

/* dv/small_language_tokenizer_tb.sv */
// Testbench top for small_language_tokenizer: drives source bytes with random
// gaps, stalls the output, reports the verdict. Depends on slt_pkg, slt_checker.
module small_language_tokenizer_tb;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	slt_pkg::in_item_t  in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	slt_pkg::out_item_t out_item;
	int                 fail_count;
	int                 pending;
	int                 cycle = 0;
	logic               calm = 1'b0;
	logic               hold_off = 1'b0;
	slt_pkg::in_item_t  src [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	small_language_tokenizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	slt_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.fail_count(fail_count), .pending(pending)
	);

	task automatic add_text(input string s, input logic eoi);
		slt_pkg::in_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.char_code = s[i];
			it.end_of_input = eoi && i == s.len() - 1;
			src.push_back(it);
		end
	endtask

	function automatic string rand_word();
		string kw [21] = '{"program", "type", "var", "procedure", "begin", "end",
			"array", "of", "record", "if", "then", "else", "fi", "char", "while", "do",
			"endwh", "read", "write", "return", "integer"};
		string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
		string s;
		int n;
		if ($urandom_range(0, 1)) return kw[$urandom_range(0, 20)];
		s = "";
		s = {s, alnum.substr($urandom_range(0, 51), $urandom_range(0, 51))};
		s = {s, alnum.substr(0, 0)};
		s = s.substr(0, 0);
		n = $urandom_range(0, 5) == 0 ? $urandom_range(9, 14) : $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			int j;
			j = $urandom_range(0, 61);
			s = {s, alnum.substr(j, j)};
		end
		return s;
	endfunction

	function automatic string rand_fragment();
		string ops [] = '{" ", "\n", ":=", "..", ".", ";", ",", "=", "<", "+", "-", "*",
			"/", "(", ")", "[", "]", ":", "'", "\t"};
		string s;
		int j;
		case ($urandom_range(0, 9))
			0, 1, 2: return rand_word();
			3: begin
				s = "";
				j = $urandom_range(0, 4) == 0 ? 14 : $urandom_range(1, 5);
				for (int i = 0; i < j; i++) s = {s, string'(byte'($urandom_range(48, 57)))};
				return s;
			end
			4: begin
				s = rand_word();
				return {"'", s.substr(0, 0),
					string'($urandom_range(0, 2) != 0 ? "'" : " ")};
			end
			5: return {"{", rand_word(), "\n}"};
			6: return string'(byte'($urandom_range(0, 255) | ($urandom_range(0, 1) << 7)));
			default: return ops[$urandom_range(0, ops.size() - 1)];
		endcase
	endfunction

	// long receiver stall so the result queue fills and in_ready drops
	initial begin
		repeat (200) @(posedge clk);
		hold_off <= 1'b1;
		repeat (60) @(posedge clk);
		hold_off <= 1'b0;
	end

	// receiver
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) out_ready <= 1'b0;
			else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				burst = $urandom_range(1, 5);
				repeat (burst - 1) @(posedge clk);
			end else out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 200000) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		slt_pkg::in_item_t it;
		string s;
		// directed: keywords, long words, numbers at and past saturation, operators,
		// char literals good and bad, comments, lone colon, dot and unknown bytes
		add_text("program procedure procedurex Abc9 ", 1'b0);
		add_text("4294967295 4294967296 99999999999 0 ", 1'b0);
		add_text(":=:a ..x.;,=<+-*/()[]", 1'b0);
		add_text("'a' 'Z 'b'' '.'7x", 1'b0);
		add_text("{c\nd}\n\t", 1'b0);
		it.char_code = 8'hFF; it.end_of_input = 1'b0; src.push_back(it);
		it.char_code = 8'h00; src.push_back(it);
		add_text("x.", 1'b1);
		add_text(":", 1'b1);
		add_text("'q", 1'b1);
		add_text("'5", 1'b1);
		add_text("'", 1'b1);
		add_text("{open", 1'b1);
		add_text("end", 1'b1);
		while (src.size() < 950) begin
			s = rand_fragment();
			add_text(s, $urandom_range(0, 40) == 0);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < src.size(); n++) begin
			if (n > src.size() - 150) calm = 1'b1;
			if (!calm && $urandom_range(0, 6) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_item <= src[n];
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
